// ----- design/gtsp_pkg.sv -----
// ----------------------------------------------------------------------------
// gtsp_pkg
// Shared types and constants for the generation-tagged slot pool: operation
// codes, register indexes, descriptor layout and controller/datapath links.
// ----------------------------------------------------------------------------
`default_nettype none

package gtsp_pkg;

  // field widths fixed by the interface
  localparam int MODE_W  = 2;
  localparam int CHAN_W  = 3;
  localparam int LEN_W   = 16;
  localparam int IDX_W   = 8;
  localparam int GEN_W   = 32;
  localparam int OSLOT_W = 3;
  localparam int CNT_W   = 4;
  localparam int STAT_W  = 32;
  localparam int LIMIT_W = 4;

  // stored descriptor: generation, channel, length
  localparam int DESC_W = GEN_W + CHAN_W + LEN_W;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOG_SLOT_LIMIT = 1'b0,
    REG_MAX_LENGTH     = 1'b1
  } reg_idx_t;

  localparam logic [LIMIT_W-1:0] LOG_SLOT_LIMIT_RESET = 4'd4;
  localparam logic [LEN_W-1:0]   MAX_LENGTH_RESET     = 16'd256;

  // operation codes
  typedef enum logic [MODE_W-1:0] {
    MODE_ALLOC    = 2'd0,
    MODE_VALIDATE = 2'd1,
    MODE_RELEASE  = 2'd2,
    MODE_NONE     = 2'd3
  } mode_t;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_SCAN = 2'd1,
    ST_READ = 2'd2,
    ST_EVAL = 2'd3
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan_step;
    logic commit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic start_scan;
    logic scan_last;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

// ----- design/gtsp_ram.sv -----
// ----------------------------------------------------------------------------
// gtsp_ram
// Generic single-clock RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module gtsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- design/gtsp_ctrl.sv -----
// ----------------------------------------------------------------------------
// gtsp_ctrl
// Controller for the slot pool: takes one request beat, runs the slot scan
// for allocations, waits for the descriptor read and commits the result.
// ----------------------------------------------------------------------------
`default_nettype none

module gtsp_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire gtsp_pkg::status_t status,
  output gtsp_pkg::cmd_t         cmd
);

  import gtsp_pkg::*;

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next    = state;
    cmd           = '0;
    in_ready      = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = status.start_scan ? ST_SCAN : ST_READ;
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.scan_last) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_EVAL;
      end
      ST_EVAL: begin
        // hold until the result register can take the new beat
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- design/gtsp_datapath.sv -----
// ----------------------------------------------------------------------------
// gtsp_datapath
// Datapath for the slot pool: request registers, per-slot flags, descriptor
// RAM, scan counter, statistics and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module gtsp_datapath #(
  parameter int SLOTS       = 8,
  parameter int LOG_CHANNEL = 3
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire gtsp_pkg::cmd_t                    cmd,
  output gtsp_pkg::status_t                      status,
  input  wire logic                              cfg_we,
  input  wire logic [gtsp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [gtsp_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic [gtsp_pkg::MODE_W-1:0]       mode,
  input  wire logic [gtsp_pkg::CHAN_W-1:0]       channel,
  input  wire logic [gtsp_pkg::LEN_W-1:0]        length,
  input  wire logic [gtsp_pkg::IDX_W-1:0]        slot_index,
  input  wire logic [gtsp_pkg::GEN_W-1:0]        generation,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic                                   ok,
  output logic      [gtsp_pkg::OSLOT_W-1:0]      out_slot,
  output logic      [gtsp_pkg::GEN_W-1:0]        out_generation,
  output logic      [gtsp_pkg::CHAN_W-1:0]       out_channel,
  output logic      [gtsp_pkg::LEN_W-1:0]        out_length,
  output logic      [gtsp_pkg::CNT_W-1:0]        used_count,
  output logic      [gtsp_pkg::CNT_W-1:0]        high_water,
  output logic      [gtsp_pkg::STAT_W-1:0]       alloc_fail_count,
  output logic      [gtsp_pkg::STAT_W-1:0]       stale_count,
  output logic      [gtsp_pkg::STAT_W-1:0]       mismatch_count
);

  import gtsp_pkg::*;

  localparam int IW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int NE   = 1 << IW;
  localparam int UW   = $clog2(SLOTS + 1);
  localparam int CMPW = (UW > LIMIT_W) ? UW : LIMIT_W;

  // configuration registers
  logic [LIMIT_W-1:0] log_slot_limit;
  logic [LEN_W-1:0]   max_length;

  // request registers
  mode_t              mode_r;
  logic [CHAN_W-1:0]  chan_r;
  logic [LEN_W-1:0]   len_r;
  logic [IDX_W-1:0]   idx_r;
  logic [GEN_W-1:0]   gen_r;
  logic               args_ok_r;

  // per-slot flags
  logic [NE-1:0] busy;
  logic [NE-1:0] written;
  logic [NE-1:0] log_owner;

  // scan state
  logic [IW-1:0] scan_idx;
  logic [IW-1:0] found_slot;
  logic          found;
  logic [UW-1:0] log_cnt;

  // statistics
  logic [UW-1:0]     used;
  logic [UW-1:0]     peak;
  logic [STAT_W-1:0] fail_cnt;
  logic [STAT_W-1:0] stale_cnt;
  logic [STAT_W-1:0] bad_cnt;

  logic              args_ok_in;
  logic              chan_is_log;
  logic              idx_ok;
  logic [IW-1:0]     idx_t;
  logic [IW-1:0]     ram_addr;
  logic [DESC_W-1:0] ram_rdata;
  logic [DESC_W-1:0] ram_wdata;
  logic              ram_we;
  logic [GEN_W-1:0]  rd_gen;
  logic [CHAN_W-1:0] rd_chan;
  logic [LEN_W-1:0]  rd_len;
  logic [GEN_W-1:0]  prev_gen;
  logic [GEN_W-1:0]  new_gen;
  logic              capped;
  logic              alloc_ok;
  logic              alloc_fail;
  logic              match;
  logic              valid_ok;
  logic              release_ok;
  logic [UW-1:0]     used_inc;

  // argument check on the incoming beat
  assign args_ok_in = (channel <= CHAN_W'(LOG_CHANNEL)) && (length != '0) &&
                      (length <= max_length);

  assign status.start_scan = (mode_t'(mode) == MODE_ALLOC) && args_ok_in;
  assign status.scan_last  = (scan_idx == IW'(SLOTS - 1));
  assign status.out_free   = !out_valid || out_ready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      log_slot_limit <= LOG_SLOT_LIMIT_RESET;
      max_length     <= MAX_LENGTH_RESET;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_LOG_SLOT_LIMIT: log_slot_limit <= cfg_data[LIMIT_W-1:0];
        REG_MAX_LENGTH:     max_length     <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r    <= mode_t'(mode);
      chan_r    <= channel;
      len_r     <= length;
      idx_r     <= slot_index;
      gen_r     <= generation;
      args_ok_r <= args_ok_in;
    end
  end

  // slot scan: lowest free slot and busy log slots, one slot a cycle
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      scan_idx   <= '0;
      found      <= 1'b0;
      found_slot <= '0;
      log_cnt    <= '0;
    end else if (cmd.scan_step) begin
      scan_idx <= scan_idx + 1'b1;
      if (!busy[scan_idx] && !found) begin
        found      <= 1'b1;
        found_slot <= scan_idx;
      end
      if (busy[scan_idx] && log_owner[scan_idx]) begin
        log_cnt <= log_cnt + 1'b1;
      end
    end
  end

  // descriptor store
  assign idx_t    = idx_r[IW-1:0];
  assign ram_addr = (mode_r == MODE_ALLOC) ? found_slot : idx_t;

  gtsp_ram #(
    .WIDTH (DESC_W),
    .DEPTH (SLOTS)
  ) u_desc_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_addr),
    .wdata (ram_wdata),
    .raddr (ram_addr),
    .rdata (ram_rdata)
  );

  assign {rd_gen, rd_chan, rd_len} = ram_rdata;

  // generation bump, skipping zero; a never-written slot starts from zero
  assign prev_gen = written[found_slot] ? rd_gen : '0;
  assign new_gen  = ((prev_gen + 1'b1) == '0) ? GEN_W'(1) : (prev_gen + 1'b1);

  // operation outcome
  assign chan_is_log = (chan_r == CHAN_W'(LOG_CHANNEL));
  assign capped      = chan_is_log && (CMPW'(log_cnt) >= CMPW'(log_slot_limit));
  assign idx_ok      = (idx_r < IDX_W'(SLOTS));
  assign match       = idx_ok && busy[idx_t] && (rd_gen == gen_r) &&
                       (rd_chan == chan_r) && (rd_len == len_r);
  assign alloc_ok    = (mode_r == MODE_ALLOC) && args_ok_r && !capped && found;
  assign alloc_fail  = (mode_r == MODE_ALLOC) && args_ok_r && !(!capped && found);
  assign valid_ok    = (mode_r == MODE_VALIDATE) && args_ok_r && match;
  assign release_ok  = (mode_r == MODE_RELEASE) && match;
  assign used_inc    = used + 1'b1;

  assign ram_we    = cmd.commit && alloc_ok;
  assign ram_wdata = {new_gen, chan_r, len_r};

  // slot flags and statistics
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= '0;
      written   <= '0;
      log_owner <= '0;
      used      <= '0;
      peak      <= '0;
      fail_cnt  <= '0;
      stale_cnt <= '0;
      bad_cnt   <= '0;
    end else if (cmd.commit) begin
      case (mode_r)
        MODE_ALLOC: begin
          if (alloc_ok) begin
            busy[found_slot]      <= 1'b1;
            written[found_slot]   <= 1'b1;
            log_owner[found_slot] <= chan_is_log;
            used                  <= used_inc;
            if (used_inc > peak) begin
              peak <= used_inc;
            end
          end else if (alloc_fail) begin
            fail_cnt <= fail_cnt + 1'b1;
          end
        end
        MODE_VALIDATE: begin
          if (!valid_ok) begin
            stale_cnt <= stale_cnt + 1'b1;
          end
        end
        MODE_RELEASE: begin
          if (release_ok) begin
            busy[idx_t] <= 1'b0;
            if (used != '0) begin
              used <= used - 1'b1;
            end
          end else begin
            bad_cnt <= bad_cnt + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      ok             <= alloc_ok || valid_ok || release_ok;
      out_slot       <= alloc_ok ? OSLOT_W'(found_slot) : '0;
      out_generation <= alloc_ok ? new_gen : '0;
      out_channel    <= alloc_ok ? chan_r : '0;
      out_length     <= alloc_ok ? len_r : '0;
    end
  end

  // statistics change only at commit, so they track the held beat
  assign used_count       = CNT_W'(used);
  assign high_water       = CNT_W'(peak);
  assign alloc_fail_count = fail_cnt;
  assign stale_count      = stale_cnt;
  assign mismatch_count   = bad_cnt;

endmodule

`default_nettype wire

// ----- design/generation_tagged_slot_pool.sv -----
// An allocate runs a scan over all SLOTS slots, one slot per cycle, that
// finds the lowest free slot and counts busy log-channel slots, then the
// registered descriptor RAM read, then the commit, which waits while the
// result register still holds an unaccepted beat. Validate, release and
// allocates with bad arguments skip the scan. One request is in flight at a
// time; the next request beat is taken while a finished result beat still
// waits in the output register. Statistics ports are live and reflect the
// state after the beat held on the result port. No clearing pass is needed
// after reset.
// ----------------------------------------------------------------------------
// generation_tagged_slot_pool
// Pool of slots handing out generation-tagged descriptors, with validate and
// release checks and wrapping usage statistics.
// ----------------------------------------------------------------------------
`default_nettype none

module generation_tagged_slot_pool #(
  parameter int SLOTS       = 8,
  parameter int LOG_CHANNEL = 3
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [gtsp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [gtsp_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [gtsp_pkg::MODE_W-1:0]       mode,
  input  wire logic [gtsp_pkg::CHAN_W-1:0]       channel,
  input  wire logic [gtsp_pkg::LEN_W-1:0]        length,
  input  wire logic [gtsp_pkg::IDX_W-1:0]        slot_index,
  input  wire logic [gtsp_pkg::GEN_W-1:0]        generation,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic                                   ok,
  output logic      [gtsp_pkg::OSLOT_W-1:0]      out_slot,
  output logic      [gtsp_pkg::GEN_W-1:0]        out_generation,
  output logic      [gtsp_pkg::CHAN_W-1:0]       out_channel,
  output logic      [gtsp_pkg::LEN_W-1:0]        out_length,
  output logic      [gtsp_pkg::CNT_W-1:0]        used_count,
  output logic      [gtsp_pkg::CNT_W-1:0]        high_water,
  output logic      [gtsp_pkg::STAT_W-1:0]       alloc_fail_count,
  output logic      [gtsp_pkg::STAT_W-1:0]       stale_count,
  output logic      [gtsp_pkg::STAT_W-1:0]       mismatch_count
);

  import gtsp_pkg::*;

  cmd_t    cmd;
  status_t status;

  // controller
  gtsp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath
  gtsp_datapath #(
    .SLOTS       (SLOTS),
    .LOG_CHANNEL (LOG_CHANNEL)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .mode             (mode),
    .channel          (channel),
    .length           (length),
    .slot_index       (slot_index),
    .generation       (generation),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .ok               (ok),
    .out_slot         (out_slot),
    .out_generation   (out_generation),
    .out_channel      (out_channel),
    .out_length       (out_length),
    .used_count       (used_count),
    .high_water       (high_water),
    .alloc_fail_count (alloc_fail_count),
    .stale_count      (stale_count),
    .mismatch_count   (mismatch_count)
  );

endmodule

`default_nettype wire

// ----- design/gtsp_checker.sv -----
// ----------------------------------------------------------------------------
// gtsp_props
// Port-level checks for the slot pool, attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module gtsp_props (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              in_valid,
  input wire logic                              in_ready,
  input wire logic                              out_valid,
  input wire logic                              out_ready,
  input wire logic                              ok,
  input wire logic [gtsp_pkg::GEN_W-1:0]        out_generation,
  input wire logic [gtsp_pkg::LEN_W-1:0]        out_length,
  input wire logic [gtsp_pkg::STAT_W-1:0]       mismatch_count
);

  // one request at a time: no request beat right after one is taken
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request beat taken while previous one in flight");

  // a stalled result beat holds its payload
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(ok) && $stable(out_generation))
    else $error("result beat changed while stalled");

  // descriptor fields are zero on a failed operation
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !ok |-> out_generation == '0 && out_length == '0)
    else $error("descriptor fields set on failed operation");

  // a new generation is never zero
  assert property (@(posedge clk) disable iff (rst)
    out_valid && ok && out_length != '0 |-> out_generation != '0)
    else $error("allocated descriptor carries generation zero");

  // mismatch count changes only together with a new result beat
  assert property (@(posedge clk) disable iff (rst)
    !out_valid |=> $stable(mismatch_count) || out_valid)
    else $error("mismatch count changed without a result beat");

endmodule

bind generation_tagged_slot_pool gtsp_props u_gtsp_props (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .ok             (ok),
  .out_generation (out_generation),
  .out_length     (out_length),
  .mismatch_count (mismatch_count)
);

`default_nettype wire
